// ===== sv/env_sensor_compensation_core_defines.svh =====
// Assertion macros shared by the compensation core.
`ifndef ENV_SENSOR_COMPENSATION_CORE_DEFINES_SVH
`define ENV_SENSOR_COMPENSATION_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ESC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define ESC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/esc_pkg.sv =====
// Shared types, constants and helpers of the sensor compensation core.
package esc_pkg;

   // Pipeline stage numbers, counted from the input register (stage 0).
   localparam int TEMP_STAGE  = 4;
   localparam int HUM_STAGE   = 10;
   localparam int OUT_STAGE   = 83;
   localparam int DIV_STEPS   = 64;

   localparam logic [31:0] T_FINE_HUM_OFS = 32'd76800;
   localparam logic [63:0] T_FINE_PRS_OFS = 64'd128000;
   localparam logic [63:0] PRS_FULL_SCALE = 64'd1048576;
   localparam logic [63:0] PRS_SCALE      = 64'd3125;
   localparam logic [31:0] HUM_CLAMP_MAX  = 32'd419430400;

   typedef enum logic [2:0] {
      REG_TEMP_TRIM    = 3'd0,
      REG_PRESS_TRIM_A = 3'd1,
      REG_PRESS_TRIM_B = 3'd2,
      REG_PRESS_TRIM_C = 3'd3,
      REG_HUM_TRIM     = 3'd4
   } esc_reg_type;

   typedef struct packed {
      logic        [15:0] t1;
      logic signed [15:0] t2;
      logic signed [15:0] t3;
      logic        [15:0] p1;
      logic signed [15:0] p2;
      logic signed [15:0] p3;
      logic signed [15:0] p4;
      logic signed [15:0] p5;
      logic signed [15:0] p6;
      logic signed [15:0] p7;
      logic signed [15:0] p8;
      logic signed [15:0] p9;
      logic        [7:0]  h1;
      logic signed [15:0] h2;
      logic        [7:0]  h3;
      logic signed [11:0] h4;
      logic signed [11:0] h5;
      logic signed [7:0]  h6;
   } esc_trim_type;

   function automatic logic [31:0] asr32(input logic [31:0] x, input int s);
      return 32'($signed(x) >>> s);
   endfunction

   function automatic logic [63:0] asr64(input logic [63:0] x, input int s);
      return 64'($signed(x) >>> s);
   endfunction

endpackage

// ===== sv/esc_mul64.sv =====
// Two-stage multiplier returning the low 64 bits of a 64 by 64 product.
module esc_mul64 (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic [63:0] p
);
   logic [63:0] ll_ff;
   logic [31:0] lh_ff;
   logic [31:0] hl_ff;
   logic [63:0] p_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         ll_ff <= 64'(a[31:0]) * 64'(b[31:0]);
         lh_ff <= 32'(a[31:0] * b[63:32]);
         hl_ff <= 32'(a[63:32] * b[31:0]);
         p_ff  <= ll_ff + {lh_ff + hl_ff, 32'd0};
      end
   end

   assign p = p_ff;
endmodule

// ===== sv/esc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, unsigned magnitudes.
module esc_div (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] dividend,
   input  logic [63:0] divisor,
   input  logic        neg,
   input  logic        zero,
   output logic [63:0] quotient,
   output logic        neg_out,
   output logic        zero_out
);
   import esc_pkg::*;

   logic [63:0] rem_ff  [0:DIV_STEPS-1];
   logic [63:0] nq_ff   [0:DIV_STEPS-1];
   logic [63:0] dsr_ff  [0:DIV_STEPS-1];
   logic        neg_ff  [0:DIV_STEPS-1];
   logic        zero_ff [0:DIV_STEPS-1];

   logic [63:0] src_rem [0:DIV_STEPS-1];
   logic [63:0] src_nq  [0:DIV_STEPS-1];
   logic [63:0] src_dsr [0:DIV_STEPS-1];
   logic        src_neg [0:DIV_STEPS-1];
   logic        src_zero[0:DIV_STEPS-1];
   logic [63:0] trial   [0:DIV_STEPS-1];
   logic        ge      [0:DIV_STEPS-1];
   logic [63:0] rem_in  [0:DIV_STEPS-1];
   logic [63:0] nq_in   [0:DIV_STEPS-1];

   always_comb begin
      src_rem[0]  = 64'd0;
      src_nq[0]   = dividend;
      src_dsr[0]  = divisor;
      src_neg[0]  = neg;
      src_zero[0] = zero;
      for (int k = 1; k < DIV_STEPS; k++) begin
         src_rem[k]  = rem_ff[k-1];
         src_nq[k]   = nq_ff[k-1];
         src_dsr[k]  = dsr_ff[k-1];
         src_neg[k]  = neg_ff[k-1];
         src_zero[k] = zero_ff[k-1];
      end
      for (int k = 0; k < DIV_STEPS; k++) begin
         // The partial remainder stays below the divisor, so its top bit is free.
         trial[k]  = {src_rem[k][62:0], src_nq[k][63]};
         ge[k]     = (trial[k] >= src_dsr[k]);
         rem_in[k] = ge[k] ? (trial[k] - src_dsr[k]) : trial[k];
         nq_in[k]  = {src_nq[k][62:0], ge[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < DIV_STEPS; k++) begin
            rem_ff[k]  <= rem_in[k];
            nq_ff[k]   <= nq_in[k];
            dsr_ff[k]  <= src_dsr[k];
            neg_ff[k]  <= src_neg[k];
            zero_ff[k] <= src_zero[k];
         end
      end
   end

   assign quotient = nq_ff[DIV_STEPS-1];
   assign neg_out  = neg_ff[DIV_STEPS-1];
   assign zero_out = zero_ff[DIV_STEPS-1];
endmodule

// ===== sv/esc_temp.sv =====
// Temperature compensation stages producing t_fine and the centidegree value.
module esc_temp (
   input  logic                 clock,
   input  logic                 en,
   input  logic [19:0]          raw_t,
   input  esc_pkg::esc_trim_type trim,
   output logic [31:0]          tfine,
   output logic [31:0]          tout
);
   import esc_pkg::*;

   logic signed [17:0] a_s;
   logic signed [16:0] b_s;
   logic signed [33:0] m1;
   logic signed [33:0] bb;
   logic signed [47:0] m3;
   logic [31:0] m1_ff, bb_ff, v1_ff, m3_ff, tfine_ff, tout_ff;

   always_comb begin
      a_s = $signed({1'b0, raw_t[19:3]}) - $signed({1'b0, trim.t1, 1'b0});
      b_s = $signed({1'b0, raw_t[19:4]}) - $signed({1'b0, trim.t1});
      m1  = a_s * trim.t2;
      bb  = b_s * b_s;
      m3  = $signed(asr32(bb_ff, 12)) * trim.t3;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_ff    <= m1[31:0];
         bb_ff    <= bb[31:0];
         v1_ff    <= asr32(m1_ff, 11);
         m3_ff    <= m3[31:0];
         tfine_ff <= v1_ff + asr32(m3_ff, 14);
         tout_ff  <= asr32({tfine_ff[29:0], 2'b00} + tfine_ff + 32'd128, 8);
      end
   end

   assign tfine = tfine_ff;
   assign tout  = tout_ff;
endmodule

// ===== sv/esc_hum.sv =====
// Humidity compensation stages with the final clamp to full scale.
module esc_hum (
   input  logic                 clock,
   input  logic                 en,
   input  logic [15:0]          raw_h,
   input  logic [31:0]          tfine,
   input  esc_pkg::esc_trim_type trim,
   output logic [16:0]          hum
);
   import esc_pkg::*;

   logic [15:0] rh_ff [1:4];
   logic [31:0] h2x, h5x, h6x, h1x, h3x, x;
   logic [31:0] m5_ff, m6_ff, m3_ff;
   logic [31:0] u1, u2, u3, u4, u5, y, hv, hc;
   logic [31:0] u1_ff, u1d_ff, p23_ff, q_ff, xx_ff, xx8_ff, xx9_ff, yy_ff, z_ff;
   logic [16:0] hum_ff;

   always_comb begin
      h1x = {24'd0, trim.h1};
      h2x = 32'(trim.h2);
      h3x = {24'd0, trim.h3};
      h5x = 32'(trim.h5);
      h6x = 32'(trim.h6);
      x   = tfine - T_FINE_HUM_OFS;
      u1  = asr32({2'b00, rh_ff[4], 14'd0} - {trim.h4, 20'd0} - m5_ff + 32'd16384, 15);
      u2  = asr32(m6_ff, 10);
      u3  = asr32(m3_ff, 11) + 32'd32768;
      u4  = asr32(p23_ff, 10) + 32'd2097152;
      u5  = asr32(q_ff + 32'd8192, 14);
      y   = asr32(xx_ff, 15);
      hv  = xx9_ff - asr32(z_ff, 4);
      if (hv[31]) begin
         hc = 32'd0;
      end else if (hv > HUM_CLAMP_MAX) begin
         hc = HUM_CLAMP_MAX;
      end else begin
         hc = hv;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rh_ff[1] <= raw_h;
         for (int k = 2; k <= 4; k++) begin
            rh_ff[k] <= rh_ff[k-1];
         end
         m5_ff  <= 32'(h5x * x);
         m6_ff  <= 32'(x * h6x);
         m3_ff  <= 32'(x * h3x);
         u1_ff  <= u1;
         p23_ff <= 32'(u2 * u3);
         u1d_ff <= u1_ff;
         q_ff   <= 32'(u4 * h2x);
         xx_ff  <= 32'(u1d_ff * u5);
         yy_ff  <= 32'(y * y);
         xx8_ff <= xx_ff;
         z_ff   <= 32'(asr32(yy_ff, 7) * h1x);
         xx9_ff <= xx8_ff;
         hum_ff <= hc[28:12];
      end
   end

   assign hum = hum_ff;
endmodule

// ===== sv/esc_press.sv =====
// Pressure compensation: 64-bit pre-division stages, divider and post stages.
module esc_press (
   input  logic                 clock,
   input  logic                 en,
   input  logic [19:0]          raw_p,
   input  logic [31:0]          tfine,
   input  esc_pkg::esc_trim_type trim,
   output logic [31:0]          press,
   output logic                 press_valid
);
   import esc_pkg::*;

   logic [19:0] rp_ff [1:8];
   logic [63:0] x1, sq, e5, e2, f6, f3, g, nm, dv, q;
   logic [63:0] e5d_ff [6:7];
   logic [63:0] e2d_ff [6:7];
   logic [63:0] x2_ff, x1b_ff, s_ff, np_ff;
   logic [63:0] an_ff, ad_ff;
   logic        neg_ff, zero_ff, div_neg, div_zero;
   logic [63:0] p_ff, ph, phph, w2r, w1r;
   logic [63:0] pd_ff [78:81];
   logic [63:0] w2d_ff [80:81];
   logic        zd_ff [77:82];
   logic [63:0] sum_ff, pfin;
   logic [31:0] press_ff;
   logic        pvalid_ff;

   assign x1 = 64'($signed(tfine)) - T_FINE_PRS_OFS;

   esc_mul64 u_sq (.clock(clock), .en(en), .a(x1), .b(x1), .p(sq));
   esc_mul64 u_e5 (.clock(clock), .en(en), .a(x1), .b(64'(trim.p5)), .p(e5));
   esc_mul64 u_e2 (.clock(clock), .en(en), .a(x1), .b(64'(trim.p2)), .p(e2));
   esc_mul64 u_f6 (.clock(clock), .en(en), .a(sq), .b(64'(trim.p6)), .p(f6));
   esc_mul64 u_f3 (.clock(clock), .en(en), .a(sq), .b(64'(trim.p3)), .p(f3));
   esc_mul64 u_g  (.clock(clock), .en(en), .a(s_ff), .b({48'd0, trim.p1}), .p(g));
   esc_mul64 u_nm (.clock(clock), .en(en), .a(np_ff), .b(PRS_SCALE), .p(nm));

   assign dv = asr64(g, 33);

   esc_div u_div (
      .clock(clock), .en(en), .dividend(an_ff), .divisor(ad_ff),
      .neg(neg_ff), .zero(zero_ff),
      .quotient(q), .neg_out(div_neg), .zero_out(div_zero)
   );

   assign ph = asr64(p_ff, 13);

   esc_mul64 u_phph (.clock(clock), .en(en), .a(ph), .b(ph), .p(phph));
   esc_mul64 u_w2   (.clock(clock), .en(en), .a(p_ff), .b(64'(trim.p8)), .p(w2r));
   esc_mul64 u_w1   (.clock(clock), .en(en), .a(phph), .b(64'(trim.p9)), .p(w1r));

   assign pfin = asr64(sum_ff, 8) + (64'(trim.p7) << 4);

   always_ff @(posedge clock) begin
      if (en) begin
         rp_ff[1] <= raw_p;
         for (int k = 2; k <= 8; k++) begin
            rp_ff[k] <= rp_ff[k-1];
         end
         e5d_ff[6] <= e5;
         e5d_ff[7] <= e5d_ff[6];
         e2d_ff[6] <= e2;
         e2d_ff[7] <= e2d_ff[6];
         x2_ff  <= f6 + (e5d_ff[7] << 17) + (64'(trim.p4) << 35);
         x1b_ff <= asr64(f3, 8) + (e2d_ff[7] << 12);
         s_ff   <= (64'd1 << 47) + x1b_ff;
         np_ff  <= ((PRS_FULL_SCALE - {44'd0, rp_ff[8]}) << 31) - x2_ff;
         an_ff   <= nm[63] ? (64'd0 - nm) : nm;
         ad_ff   <= dv[63] ? (64'd0 - dv) : dv;
         neg_ff  <= nm[63] ^ dv[63];
         zero_ff <= (dv == 64'd0);
         p_ff      <= div_neg ? (64'd0 - q) : q;
         zd_ff[77] <= div_zero;
         for (int k = 78; k <= 82; k++) begin
            zd_ff[k] <= zd_ff[k-1];
         end
         pd_ff[78] <= p_ff;
         for (int k = 79; k <= 81; k++) begin
            pd_ff[k] <= pd_ff[k-1];
         end
         w2d_ff[80] <= w2r;
         w2d_ff[81] <= w2d_ff[80];
         sum_ff    <= pd_ff[81] + asr64(w1r, 25) + asr64(w2d_ff[81], 19);
         press_ff  <= zd_ff[82] ? 32'd0 : pfin[31:0];
         pvalid_ff <= !zd_ff[82];
      end
   end

   assign press       = press_ff;
   assign press_valid = pvalid_ff;
endmodule

// ===== sv/env_sensor_compensation_core.sv =====
// Throughput: one sample triple per cycle unless the result side stalls; the 64-stage
// pressure divider sets the depth. A stall on the result side freezes every stage
// together, so nothing is lost or repeated. Reset (synchronous, active high) clears the
// stage valid bits and all trim registers. The user writes the trim registers through
// the csr port only while the pipeline is empty; the core does not enforce this.
module env_sensor_compensation_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // raw_temperature[19:0], raw_pressure[39:20], raw_humidity[55:40]
   input  logic [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // temperature_centi[31:0], pressure_q24_8[63:32], humidity_q22_10[80:64], zero fill
   output logic [87:0] rsp_tdata,
   // pressure_valid[0]
   output logic [0:0]  rsp_tuser,
   input  logic        csr_wen,
   input  logic [2:0]  csr_addr,
   input  logic [63:0] csr_wdata
);
   import esc_pkg::*;

`include "env_sensor_compensation_core_defines.svh"

   // Trim registers, held exactly as written.
   logic [47:0] temp_trim_ff;
   logic [63:0] press_a_ff;
   logic [63:0] press_b_ff;
   logic [15:0] press_c_ff;
   logic [63:0] hum_trim_ff;
   esc_trim_type trim;

   // The whole pipeline moves when the output stage is empty or being taken.
   logic pipe_en;
   logic vld_ff [0:OUT_STAGE];

   logic [19:0] raw_t_ff, raw_p_ff;
   logic [15:0] raw_h_ff;

   logic [31:0] tfine, tout, press;
   logic [16:0] hum;
   logic        press_valid;
   logic [31:0] tout_dly_ff [TEMP_STAGE+1:OUT_STAGE];
   logic [16:0] hum_dly_ff  [HUM_STAGE+1:OUT_STAGE];

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_trim_ff <= '0;
         press_a_ff   <= '0;
         press_b_ff   <= '0;
         press_c_ff   <= '0;
         hum_trim_ff  <= '0;
      end else if (csr_wen) begin
         unique case (csr_addr)
            REG_TEMP_TRIM:    temp_trim_ff <= csr_wdata[47:0];
            REG_PRESS_TRIM_A: press_a_ff   <= csr_wdata;
            REG_PRESS_TRIM_B: press_b_ff   <= csr_wdata;
            REG_PRESS_TRIM_C: press_c_ff   <= csr_wdata[15:0];
            REG_HUM_TRIM:     hum_trim_ff  <= csr_wdata;
            default: begin
               // Writes beyond the register list are dropped.
            end
         endcase
      end
   end

   always_comb begin
      trim.t1 = temp_trim_ff[15:0];
      trim.t2 = temp_trim_ff[31:16];
      trim.t3 = temp_trim_ff[47:32];
      trim.p1 = press_a_ff[15:0];
      trim.p2 = press_a_ff[31:16];
      trim.p3 = press_a_ff[47:32];
      trim.p4 = press_a_ff[63:48];
      trim.p5 = press_b_ff[15:0];
      trim.p6 = press_b_ff[31:16];
      trim.p7 = press_b_ff[47:32];
      trim.p8 = press_b_ff[63:48];
      trim.p9 = press_c_ff;
      trim.h1 = hum_trim_ff[7:0];
      trim.h2 = hum_trim_ff[23:8];
      trim.h3 = hum_trim_ff[31:24];
      trim.h4 = hum_trim_ff[43:32];
      trim.h5 = hum_trim_ff[55:44];
      trim.h6 = hum_trim_ff[63:56];
   end

   assign pipe_en    = !vld_ff[OUT_STAGE] || rsp_tready;
   assign req_tready = pipe_en;

   // Valid bits ride alongside the data stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= OUT_STAGE; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (pipe_en) begin
         vld_ff[0] <= req_tvalid;
         for (int k = 1; k <= OUT_STAGE; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // Stage 0 captures the sample triple of an accepted transaction.
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         raw_t_ff <= req_tdata[19:0];
         raw_p_ff <= req_tdata[39:20];
         raw_h_ff <= req_tdata[55:40];
      end
   end

   esc_temp u_temp (
      .clock(clock), .en(pipe_en), .raw_t(raw_t_ff), .trim(trim),
      .tfine(tfine), .tout(tout)
   );

   esc_hum u_hum (
      .clock(clock), .en(pipe_en), .raw_h(raw_h_ff), .tfine(tfine), .trim(trim),
      .hum(hum)
   );

   esc_press u_press (
      .clock(clock), .en(pipe_en), .raw_p(raw_p_ff), .tfine(tfine), .trim(trim),
      .press(press), .press_valid(press_valid)
   );

   // Temperature and humidity finish early and wait for the pressure path.
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         tout_dly_ff[TEMP_STAGE+1] <= tout;
         for (int k = TEMP_STAGE + 2; k <= OUT_STAGE; k++) begin
            tout_dly_ff[k] <= tout_dly_ff[k-1];
         end
         hum_dly_ff[HUM_STAGE+1] <= hum;
         for (int k = HUM_STAGE + 2; k <= OUT_STAGE; k++) begin
            hum_dly_ff[k] <= hum_dly_ff[k-1];
         end
      end
   end

   assign rsp_tvalid = vld_ff[OUT_STAGE];
   assign rsp_tdata  = {7'd0, hum_dly_ff[OUT_STAGE], press, tout_dly_ff[OUT_STAGE]};
   assign rsp_tuser  = press_valid;

   // A pressure result flagged invalid must carry zero.
   `ESC_ASSERT_NOW(a_press_zero, clock, reset, rsp_tvalid && !rsp_tuser[0], rsp_tdata[63:32] == 32'd0, "invalid pressure not zero")
   // Humidity never exceeds full scale after the clamp.
   `ESC_ASSERT_NOW(a_hum_range, clock, reset, rsp_tvalid, rsp_tdata[80:64] <= 17'd102400, "humidity above full scale")
   // An accepted transaction occupies the first stage on the next cycle.
   `ESC_ASSERT_NEXT(a_accept_enters, clock, reset, req_tvalid && req_tready, vld_ff[0], "accepted transaction lost at entry")
endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the sensor compensation core: scoreboard, predictor and drivers.
`timescale 1ns / 1ps

module tb_top;
   import esc_pkg::*;

   // Long enough for every sample to wait out the longest sender gap, the longest
   // receiver stall and the full pipeline depth, with a wide margin on top.
   localparam int CYCLE_LIMIT = 400000;
   localparam int PIPE_DRAIN  = OUT_STAGE + 10;
   localparam int LONG_HOLD   = 400;

   // Register indexes outside the defined list; writes to them must be ignored.
   localparam logic [2:0] REG_SPARE_LO = 3'd5;
   localparam logic [2:0] REG_SPARE_HI = 3'd7;

   // One compensated result, split into its fields.
   typedef struct packed {
      logic signed [31:0] temperature_centi;
      logic        [31:0] pressure_q24_8;
      logic               pressure_valid;
      logic        [16:0] humidity_q22_10;
   } comp_result_type;

   // The scoreboard holds the compensated results still owed by the core, oldest first.
   class sample_scoreboard;
      comp_result_type pending[$];
      int              mismatches;
      int              compared;

      function void note_sample(comp_result_type exp_res);
         pending.push_back(exp_res);
      endfunction

      // Prints one line for a mismatch and counts it.
      task report(string what, logic [63:0] got, logic [63:0] want);
         mismatches++;
         $display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
      endtask

      task check_result(comp_result_type got);
         comp_result_type want;
         if (pending.size() == 0) begin
            report("result with nothing outstanding", 64'(got), 64'd0);
            return;
         end
         want = pending.pop_front();
         compared++;
         if (got.temperature_centi !== want.temperature_centi)
            report("temperature_centi", 64'(got.temperature_centi),
                   64'(want.temperature_centi));
         if (got.pressure_q24_8 !== want.pressure_q24_8)
            report("pressure_q24_8", 64'(got.pressure_q24_8), 64'(want.pressure_q24_8));
         if (got.pressure_valid !== want.pressure_valid)
            report("pressure_valid", 64'(got.pressure_valid), 64'(want.pressure_valid));
         if (got.humidity_q22_10 !== want.humidity_q22_10)
            report("humidity_q22_10", 64'(got.humidity_q22_10), 64'(want.humidity_q22_10));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [55:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [87:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_wen;
   logic [2:0]  csr_addr;
   logic [63:0] csr_wdata;

   // Local copy of the trim registers, updated on every write the core accepts.
   logic [47:0] temp_trim;
   logic [63:0] press_trim_a;
   logic [63:0] press_trim_b;
   logic [15:0] press_trim_c;
   logic [63:0] hum_trim;

   sample_scoreboard results_sb;
   int               cycle_count;
   int               samples_sent;
   int               invalid_pressure_seen;
   int               settings_used;
   logic             quiet;       // when set, neither side idles
   logic             hold_req;    // asks the receiver for one long stall
   logic             hold_done;   // the long stall has been taken
   int               stall_left;

   env_sensor_compensation_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // Arithmetic right shifts on raw bit patterns, as the compensation formulas use them.
   function automatic logic [31:0] sra32(input logic [31:0] v, input int n);
      return $unsigned($signed(v) >>> n);
   endfunction

   function automatic logic [63:0] sra64(input logic [63:0] v, input int n);
      return $unsigned($signed(v) >>> n);
   endfunction

   // Signed division that truncates toward zero and wraps for the most negative
   // dividend over minus one, done on magnitudes; only a zero divisor gives an undefined result.
   function automatic logic [63:0] div_trunc64(input logic [63:0] n, input logic [63:0] d);
      logic [63:0] mag_n;
      logic [63:0] mag_d;
      logic [63:0] quo;
      mag_n = n[63] ? -n : n;
      mag_d = d[63] ? -d : d;
      quo   = mag_n / mag_d;
      return (n[63] != d[63]) ? -quo : quo;
   endfunction

   // Computes the compensated result of one raw sample triple from the trim copy.
   function automatic comp_result_type compensate(input logic [55:0] raw);
      comp_result_type res;
      logic [31:0] rt, rh, t1, t2, t3, a, b, v1, v2, t_fine, prod;
      logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [63:0] x1, x2, pr, ph, w1, w2;
      logic [31:0] h1, h2, h3, h4, h5, h6, hx, u1, u2, u3, u4, u5, hy;
      rt = {12'd0, raw[19:0]};
      rh = {16'd0, raw[55:40]};

      // Temperature path wraps at 32 bits.
      t1 = {16'd0, temp_trim[15:0]};
      t2 = {{16{temp_trim[31]}}, temp_trim[31:16]};
      t3 = {{16{temp_trim[47]}}, temp_trim[47:32]};
      a  = (rt >> 3) - (t1 << 1);
      prod = a * t2;
      v1 = sra32(prod, 11);
      b  = (rt >> 4) - t1;
      prod = b * b;
      prod = sra32(prod, 12) * t3;
      v2 = sra32(prod, 14);
      t_fine = v1 + v2;
      res.temperature_centi = sra32(t_fine * 32'd5 + 32'd128, 8);

      // Pressure path wraps at 64 bits.
      p1 = {48'd0, press_trim_a[15:0]};
      p2 = {{48{press_trim_a[31]}}, press_trim_a[31:16]};
      p3 = {{48{press_trim_a[47]}}, press_trim_a[47:32]};
      p4 = {{48{press_trim_a[63]}}, press_trim_a[63:48]};
      p5 = {{48{press_trim_b[15]}}, press_trim_b[15:0]};
      p6 = {{48{press_trim_b[31]}}, press_trim_b[31:16]};
      p7 = {{48{press_trim_b[47]}}, press_trim_b[47:32]};
      p8 = {{48{press_trim_b[63]}}, press_trim_b[63:48]};
      p9 = {{48{press_trim_c[15]}}, press_trim_c};
      x1 = {{32{t_fine[31]}}, t_fine} - 64'd128000;
      x2 = x1 * x1 * p6;
      x2 = x2 + ((x1 * p5) << 17);
      x2 = x2 + (p4 << 35);
      x1 = sra64(x1 * x1 * p3, 8) + ((x1 * p2) << 12);
      x1 = sra64(((64'd1 << 47) + x1) * p1, 33);
      if (x1 == 64'd0) begin
         // A zero divisor forces the pressure to zero and flags it invalid.
         res.pressure_q24_8 = 32'd0;
         res.pressure_valid = 1'b0;
      end else begin
         pr = 64'd1048576 - {44'd0, raw[39:20]};
         pr = div_trunc64(((pr << 31) - x2) * 64'd3125, x1);
         ph = sra64(pr, 13);
         w1 = sra64(p9 * ph * ph, 25);
         w2 = sra64(p8 * pr, 19);
         pr = sra64(pr + w1 + w2, 8) + (p7 << 4);
         res.pressure_q24_8 = pr[31:0];
         res.pressure_valid = 1'b1;
      end

      // Humidity path wraps at 32 bits and is clamped at the end.
      h1 = {24'd0, hum_trim[7:0]};
      h2 = {{16{hum_trim[23]}}, hum_trim[23:8]};
      h3 = {24'd0, hum_trim[31:24]};
      h4 = {{20{hum_trim[43]}}, hum_trim[43:32]};
      h5 = {{20{hum_trim[55]}}, hum_trim[55:44]};
      h6 = {{24{hum_trim[63]}}, hum_trim[63:56]};
      hx = t_fine - 32'd76800;
      u1 = sra32(((rh << 14) - (h4 << 20) - (h5 * hx)) + 32'd16384, 15);
      u2 = sra32(hx * h6, 10);
      u3 = sra32(hx * h3, 11) + 32'd32768;
      u4 = sra32(u2 * u3, 10) + 32'd2097152;
      u5 = sra32(u4 * h2 + 32'd8192, 14);
      hx = u1 * u5;
      hy = sra32(hx, 15);
      prod = sra32(hy * hy, 7) * h1;
      hx = hx - sra32(prod, 4);
      if (hx[31])
         hx = 32'd0;
      if (hx > 32'd419430400)
         hx = 32'd419430400;
      res.humidity_q22_10 = hx[28:12];
      return res;
   endfunction

   // Every sample the core takes is predicted at the edge where it is accepted.
   // Trim writes only happen while the pipeline is empty, so the copy is stable here.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         results_sb.note_sample(compensate(req_tdata));
   end

   // Every result the core hands over is compared against the oldest prediction.
   always @(posedge clock) begin
      comp_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.temperature_centi = rsp_tdata[31:0];
         got.pressure_q24_8    = rsp_tdata[63:32];
         got.pressure_valid    = rsp_tuser[0];
         got.humidity_q22_10   = rsp_tdata[80:64];
         if (!rsp_tuser[0])
            invalid_pressure_seen++;
         results_sb.check_result(got);
      end
   end

   // Result-side back-pressure. Short random stalls come at random; one long stall, counted
   // here, lets the pipeline fill up and stall its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
         hold_done  <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_req && !hold_done) begin
         stall_left <= LONG_HOLD - 1;
         hold_done  <= 1'b1;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 7);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   // Writes one trim register and mirrors it; spare indexes leave the copy alone.
   task automatic write_trim(input logic [2:0] idx, input logic [63:0] value);
      csr_wen   <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      case (idx)
         REG_TEMP_TRIM:    temp_trim    = value[47:0];
         REG_PRESS_TRIM_A: press_trim_a = value;
         REG_PRESS_TRIM_B: press_trim_b = value;
         REG_PRESS_TRIM_C: press_trim_c = value[15:0];
         REG_HUM_TRIM:     hum_trim     = value;
         default: ;
      endcase
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   task automatic load_trims(input logic [47:0] tt, input logic [63:0] pa,
                             input logic [63:0] pb, input logic [15:0] pc,
                             input logic [63:0] ht);
      write_trim(REG_TEMP_TRIM, {16'd0, tt});
      write_trim(REG_PRESS_TRIM_A, pa);
      write_trim(REG_PRESS_TRIM_B, pb);
      write_trim(REG_PRESS_TRIM_C, {48'd0, pc});
      write_trim(REG_HUM_TRIM, ht);
      settings_used++;
   endtask

   // Offers one sample, after an optional random gap, and holds it until it is taken.
   task automatic send_sample(input logic [19:0] rt, input logic [19:0] rp,
                              input logic [15:0] rh);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {rh, rp, rt};
      do @(posedge clock); while (!req_tready);
      samples_sent++;
   endtask

   // Random samples: mostly readings near a real operating point, the rest full range.
   task automatic send_random(input int count);
      repeat (count) begin
         if ($urandom_range(0, 3) != 0)
            send_sample(20'($urandom_range(20'h60000, 20'h90000)),
                        20'($urandom_range(20'h50000, 20'h70000)),
                        16'($urandom_range(16'h4000, 16'h8000)));
         else
            send_sample(20'($urandom), 20'($urandom), 16'($urandom));
      end
   endtask

   // Lets the pipeline empty out before the trims change or the run ends.
   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_sb.pending.size() != 0) @(posedge clock);
      repeat (PIPE_DRAIN) @(posedge clock);
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_wen    = 1'b0;
      csr_addr   = REG_TEMP_TRIM;
      csr_wdata  = '0;
      quiet      = 1'b0;
      hold_req   = 1'b0;
      samples_sent = 0;
      settings_used = 1;
      temp_trim = '0;
      press_trim_a = '0;
      press_trim_b = '0;
      press_trim_c = '0;
      hum_trim = '0;
      results_sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // All trims at their reset value of zero: the pressure divisor is zero.
      send_sample(20'd0, 20'd0, 16'd0);
      send_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
      send_sample(20'h7EED0, 20'h655AC, 16'h6000);
      drain();

      // Typical factory trims, with field extremes and the humidity clamps first.
      load_trims(48'hFC18_6743_6B70, 64'h0B27_0BD0_D643_8E7D, 64'hC6F8_3C8C_FFF9_008C,
                 16'h1770, 64'h1E00_0144_0001_6A4B);
      send_sample(20'h7EED0, 20'h655AC, 16'h6000);
      send_sample(20'd0, 20'd0, 16'd0);
      send_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
      send_sample(20'hFFFFF, 20'd0, 16'h0000);
      send_sample(20'd0, 20'hFFFFF, 16'hFFFF);
      send_sample(20'h7EED0, 20'h80000, 16'hFFFF);
      send_sample(20'h7EED0, 20'h00001, 16'h0001);
      send_sample(20'h55555, 20'hAAAAA, 16'h5555);
      send_sample(20'hAAAAA, 20'h55555, 16'hAAAA);
      // One long result-side stall while samples keep coming.
      hold_req <= 1'b1;
      send_random(400);
      drain();

      // Every trim bit set: signed coefficients at minus one, unsigned at maximum.
      load_trims('1, '1, '1, '1, '1);
      write_trim(REG_SPARE_LO, 64'h0123_4567_89AB_CDEF);
      write_trim(REG_SPARE_HI, '0);
      send_random(150);
      drain();

      // Most negative signed coefficients, but for h4 and h5, with unsigned ones at maximum.
      load_trims(48'h8000_8000_FFFF, 64'h8000_8000_8000_FFFF, 64'h8000_8000_8000_8000,
                 16'h8000, 64'h8008_0080_FF80_00FF);
      send_random(150);
      drain();

      // Most positive signed coefficients.
      load_trims(48'h7FFF_7FFF_0001, 64'h7FFF_7FFF_7FFF_0001, 64'h7FFF_7FFF_7FFF_7FFF,
                 16'h7FFF, 64'h7F7F_F7FF_007F_FF01);
      send_random(100);
      drain();

      // Random trims, several settings.
      repeat (4) begin
         load_trims(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
                    16'($urandom), {$urandom, $urandom});
         send_random(100);
         drain();
      end

      // Back to typical trims with both sides running flat out.
      load_trims(48'hFC18_6743_6B70, 64'h0B27_0BD0_D643_8E7D, 64'hC6F8_3C8C_FFF9_008C,
                 16'h1770, 64'h1E00_0144_0001_6A4B);
      quiet <= 1'b1;
      send_random(200);
      drain();

      $display("Sent %0d samples over %0d trim settings, %0d results compared.",
               samples_sent, settings_used, results_sb.compared);
      $display("Results with a zero pressure divisor: %0d; mismatches: %0d.",
               invalid_pressure_seen, results_sb.mismatches);
      if (results_sb.mismatches == 0 && results_sb.pending.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule

// ===== env_sensor_compensation_core.f =====
+incdir+sv
sv/esc_pkg.sv
sv/esc_mul64.sv
sv/esc_div.sv
sv/esc_temp.sv
sv/esc_hum.sv
sv/esc_press.sv
sv/env_sensor_compensation_core.sv
verif/tb_top.sv
